// ===== rtl/core/gpio_controller_with_irq_detect_assert.svh =====
// Assertion macros used by the checker file of the GPIO controller.
// Both expect clk_i and rst_ni to be visible where they are used.
`ifndef GPIO_CONTROLLER_WITH_IRQ_DETECT_ASSERT_SVH
`define GPIO_CONTROLLER_WITH_IRQ_DETECT_ASSERT_SVH

// Same-cycle implication.
`define GPIOC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpioc: same-cycle check failed");

// Next-cycle implication.
`define GPIOC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpioc: next-cycle check failed");

`endif

// ===== rtl/core/gpioc_pkg.sv =====
package gpioc_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_PIN   = 2'd2,
    KIND_SRC   = 2'd3
  } kind_e;

  // GPIO register groups, selected by offset bits [6:5]
  typedef enum logic [1:0] {
    GREG_DATA = 2'd0,
    GREG_DIR  = 2'd1,
    GREG_SET  = 2'd2,
    GREG_CLR  = 2'd3
  } greg_e;

  // Interrupt registers, word offset inside an interrupt bank
  localparam logic [3:0] IREG_STATUS = 4'd0;
  localparam logic [3:0] IREG_ENABLE = 4'd4;
  localparam logic [3:0] IREG_TYPE   = 4'd8;
  localparam logic [3:0] IREG_POL    = 4'd9;
  localparam logic [3:0] IREG_EDGE   = 4'd10;

  localparam int unsigned WordW = 32;

  typedef struct packed {
    kind_e             kind;
    logic [5:0]        word;    // reg_offset[7:2]
    logic [WordW-1:0]  wdata;
    logic [2:0]        sbank;
    logic [WordW-1:0]  levels;
  } gpioc_item_t;

  // Interrupt bank 0 has 32 sources, bank 1 has 8
  function automatic logic [WordW-1:0] irq_src_mask(input logic bank1);
    irq_src_mask = bank1 ? 32'h0000_00ff : 32'hffff_ffff;
  endfunction

endpackage

// ===== rtl/core/gpioc_in_reg.sv =====
module gpioc_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  gpioc_pkg::gpioc_item_t item_i,
  input  logic                  take_i,
  output logic                  fire_o,
  output gpioc_pkg::gpioc_item_t item_o
);
  import gpioc_pkg::*;

  logic        valid_q, valid_d;
  gpioc_item_t item_q;

  assign fire_o  = valid_q && take_i;
  assign ready_o = !valid_q || take_i;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/core/gpioc_gpio_banks.sv =====
module gpioc_gpio_banks #(
  parameter int unsigned GPIO_BANKS = 8,
  parameter int unsigned BANK_BITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  gpioc_pkg::gpioc_item_t item_i,
  output logic [31:0]            rdata_o,
  output logic [2:0]             drive_bank_o,
  output logic [31:0]            drive_level_o,
  output logic [31:0]            drive_enable_o
);
  import gpioc_pkg::*;

  logic [BANK_BITS-1:0] latch_q [GPIO_BANKS];
  logic [BANK_BITS-1:0] latch_d [GPIO_BANKS];
  logic [BANK_BITS-1:0] dir_q   [GPIO_BANKS];
  logic [BANK_BITS-1:0] dir_d   [GPIO_BANKS];
  logic [BANK_BITS-1:0] pin_q   [GPIO_BANKS];
  logic [BANK_BITS-1:0] pin_d   [GPIO_BANKS];

  logic                 is_reg;
  greg_e                region;
  logic [2:0]           abank;
  logic [BANK_BITS-1:0] wd;

  assign is_reg = ((item_i.kind == KIND_READ) || (item_i.kind == KIND_WRITE)) &&
                  !item_i.word[5];
  assign region = greg_e'(item_i.word[4:3]);
  assign abank  = item_i.word[2:0];
  assign wd     = item_i.wdata[BANK_BITS-1:0];

  assign drive_bank_o = is_reg ? abank :
                        (item_i.kind == KIND_PIN) ? item_i.sbank : 3'd0;

  always_comb begin
    for (int i = 0; i < GPIO_BANKS; i++) begin
      latch_d[i] = latch_q[i];
      dir_d[i]   = dir_q[i];
      pin_d[i]   = pin_q[i];
      if (fire_i && is_reg && (item_i.kind == KIND_WRITE) && (abank == 3'(i))) begin
        case (region)
          GREG_DATA: latch_d[i] = wd;
          GREG_DIR:  dir_d[i]   = wd;
          GREG_SET:  latch_d[i] = latch_q[i] | wd;
          GREG_CLR:  latch_d[i] = latch_q[i] & ~wd;
          default:   latch_d[i] = latch_q[i];
        endcase
      end
      if (fire_i && (item_i.kind == KIND_PIN) && (item_i.sbank == 3'(i))) begin
        pin_d[i] = item_i.levels[BANK_BITS-1:0];
      end
    end
  end

  // Reads see the state before the beat; drive values see it after
  always_comb begin
    rdata_o        = '0;
    drive_level_o  = '0;
    drive_enable_o = '0;
    for (int i = 0; i < GPIO_BANKS; i++) begin
      if (is_reg && (item_i.kind == KIND_READ) && (abank == 3'(i))) begin
        case (region)
          GREG_DATA: rdata_o = 32'((latch_q[i] & dir_q[i]) | (pin_q[i] & ~dir_q[i]));
          GREG_DIR:  rdata_o = 32'(dir_q[i]);
          default:   rdata_o = '0;
        endcase
      end
      if (drive_bank_o == 3'(i)) begin
        drive_level_o  = 32'(latch_d[i]);
        drive_enable_o = 32'(dir_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GPIO_BANKS; i++) begin
        latch_q[i] <= '0;
        dir_q[i]   <= '0;
        pin_q[i]   <= '0;
      end
    end else begin
      latch_q <= latch_d;
      dir_q   <= dir_d;
      pin_q   <= pin_d;
    end
  end

endmodule

// ===== rtl/core/gpioc_irq_unit.sv =====
module gpioc_irq_unit #(
  parameter int unsigned INTR_BANKS = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  gpioc_pkg::gpioc_item_t item_i,
  output logic [31:0]            rdata_o,
  output logic                   irq_o
);
  import gpioc_pkg::*;

  logic [WordW-1:0] status_q [INTR_BANKS];
  logic [WordW-1:0] status_d [INTR_BANKS];
  logic [WordW-1:0] enable_q [INTR_BANKS];
  logic [WordW-1:0] enable_d [INTR_BANKS];
  logic [WordW-1:0] ltype_q  [INTR_BANKS];
  logic [WordW-1:0] ltype_d  [INTR_BANKS];
  logic [WordW-1:0] inv_q    [INTR_BANKS];
  logic [WordW-1:0] inv_d    [INTR_BANKS];
  logic [WordW-1:0] both_q   [INTR_BANKS];
  logic [WordW-1:0] both_d   [INTR_BANKS];
  logic [WordW-1:0] prev_q   [INTR_BANKS];
  logic [WordW-1:0] prev_d   [INTR_BANKS];

  logic       is_reg;
  logic [2:0] ibank;
  logic [3:0] rel;

  assign is_reg = ((item_i.kind == KIND_READ) || (item_i.kind == KIND_WRITE)) &&
                  item_i.word[5];
  assign ibank  = {2'b00, item_i.word[4]};
  assign rel    = item_i.word[3:0];

  always_comb begin
    logic [WordW-1:0] mask, cur, x, px, edge_hit;
    mask     = '0;
    cur      = '0;
    x        = '0;
    px       = '0;
    edge_hit = '0;
    for (int i = 0; i < INTR_BANKS; i++) begin
      status_d[i] = status_q[i];
      enable_d[i] = enable_q[i];
      ltype_d[i]  = ltype_q[i];
      inv_d[i]    = inv_q[i];
      both_d[i]   = both_q[i];
      prev_d[i]   = prev_q[i];
      mask        = irq_src_mask(i == 1);
      if (fire_i && is_reg && (item_i.kind == KIND_WRITE) && (ibank == 3'(i))) begin
        case (rel)
          IREG_STATUS: status_d[i] = status_q[i] & ~item_i.wdata;
          IREG_ENABLE: enable_d[i] = item_i.wdata & mask;
          IREG_TYPE:   ltype_d[i]  = item_i.wdata & mask;
          IREG_POL:    inv_d[i]    = item_i.wdata & mask;
          IREG_EDGE:   both_d[i]   = item_i.wdata & mask;
          default:     status_d[i] = status_q[i];
        endcase
      end
      if (fire_i && (item_i.kind == KIND_SRC) && (item_i.sbank == 3'(i))) begin
        cur         = item_i.levels & mask;
        x           = cur ^ inv_q[i];
        px          = prev_q[i] ^ inv_q[i];
        edge_hit    = (both_q[i] & (cur ^ prev_q[i])) | (~both_q[i] & x & ~px);
        status_d[i] = status_q[i] |
                      (((ltype_q[i] & x) | (~ltype_q[i] & edge_hit)) & mask);
        prev_d[i]   = cur;
      end
    end
  end

  always_comb begin
    rdata_o = '0;
    irq_o   = 1'b0;
    for (int i = 0; i < INTR_BANKS; i++) begin
      if (is_reg && (item_i.kind == KIND_READ) && (ibank == 3'(i))) begin
        case (rel)
          IREG_STATUS: rdata_o = status_q[i];
          IREG_ENABLE: rdata_o = enable_q[i];
          IREG_TYPE:   rdata_o = ltype_q[i];
          IREG_POL:    rdata_o = inv_q[i];
          IREG_EDGE:   rdata_o = both_q[i];
          default:     rdata_o = '0;
        endcase
      end
      if ((status_d[i] & enable_d[i]) != '0) begin
        irq_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < INTR_BANKS; i++) begin
        status_q[i] <= '0;
        enable_q[i] <= '0;
        ltype_q[i]  <= '0;
        inv_q[i]    <= '0;
        both_q[i]   <= '0;
        prev_q[i]   <= '0;
      end
    end else begin
      status_q <= status_d;
      enable_q <= enable_d;
      ltype_q  <= ltype_d;
      inv_q    <= inv_d;
      both_q   <= both_d;
      prev_q   <= prev_d;
    end
  end

endmodule

// ===== rtl/core/gpio_controller_with_irq_detect.sv =====
// Input beat to result beat: input register, decode and bank update, result register.
// Throughput: one item per cycle unless the result side is stalled by out_ready_i.
// in_ready_o stays high whenever the result register is empty or being taken.
// Reset: asynchronous, clears all banks to zero (all pins inputs, interrupts off, edge
// type, normal polarity); no clearing pass, items are taken from the first cycle.
module gpio_controller_with_irq_detect #(
  parameter int unsigned GPIO_BANKS = 8,
  parameter int unsigned BANK_BITS  = 32,
  parameter int unsigned INTR_BANKS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  reg_offset_i,
  input  logic [31:0] write_data_i,
  input  logic [2:0]  sample_bank_i,
  input  logic [31:0] sample_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [2:0]  drive_bank_o,
  output logic [31:0] drive_level_o,
  output logic [31:0] drive_enable_o,
  output logic        irq_out_o
);
  import gpioc_pkg::*;

  gpioc_item_t in_item, cur_item;
  logic        take, fire;
  logic [31:0] gpio_rdata, irq_rdata, drive_level, drive_enable;
  logic [2:0]  drive_bank;
  logic        irq;

  logic        out_valid_q, out_valid_d;
  logic [31:0] read_data_q, drive_level_q, drive_enable_q;
  logic [2:0]  drive_bank_q;
  logic        irq_q;

  assign in_item.kind   = kind_e'(kind_i);
  assign in_item.word   = reg_offset_i[7:2];
  assign in_item.wdata  = write_data_i;
  assign in_item.sbank  = sample_bank_i;
  assign in_item.levels = sample_levels_i;

  assign take = !out_valid_q || out_ready_i;

  gpioc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .take_i  (take),
    .fire_o  (fire),
    .item_o  (cur_item)
  );

  gpioc_gpio_banks #(
    .GPIO_BANKS (GPIO_BANKS),
    .BANK_BITS  (BANK_BITS)
  ) u_gpio_banks (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (cur_item),
    .rdata_o        (gpio_rdata),
    .drive_bank_o   (drive_bank),
    .drive_level_o  (drive_level),
    .drive_enable_o (drive_enable)
  );

  gpioc_irq_unit #(
    .INTR_BANKS (INTR_BANKS)
  ) u_irq_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (cur_item),
    .rdata_o (irq_rdata),
    .irq_o   (irq)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Only one of the two read paths decodes a given offset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_data_q    <= gpio_rdata | irq_rdata;
      drive_bank_q   <= drive_bank;
      drive_level_q  <= drive_level;
      drive_enable_q <= drive_enable;
      irq_q          <= irq;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = read_data_q;
  assign drive_bank_o   = drive_bank_q;
  assign drive_level_o  = drive_level_q;
  assign drive_enable_o = drive_enable_q;
  assign irq_out_o      = irq_q;

endmodule

// ===== rtl/core/gpioc_checker.sv =====
`include "gpio_controller_with_irq_detect_assert.svh"

module gpioc_checker #(
  parameter int unsigned GPIO_BANKS = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic [2:0]  drive_bank_o,
  input logic [31:0] drive_level_o,
  input logic [31:0] drive_enable_o,
  input logic        irq_out_o
);

  // A bank beyond the implemented ones drives nothing
  `GPIOC_ASSERT_IMP(a_unmapped_bank_quiet, out_valid_o && ({1'b0, drive_bank_o} >= 4'(GPIO_BANKS)), (drive_level_o == '0) && (drive_enable_o == '0))

  // A fresh result beat follows an input beat taken by the input register and then passed to the result register
  `GPIOC_ASSERT_IMP(a_result_from_input, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2))

  // Input side never stalls unless the result side does
  `GPIOC_ASSERT_IMP(a_no_needless_stall, !out_valid_o || out_ready_i, in_ready_o)

  // Hold a stalled result beat
  `GPIOC_ASSERT_NXT(a_result_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(read_data_o) && $stable(drive_bank_o) && $stable(drive_level_o) && $stable(drive_enable_o) && $stable(irq_out_o))

endmodule

bind gpio_controller_with_irq_detect gpioc_checker #(
  .GPIO_BANKS (GPIO_BANKS)
) u_gpioc_checker (.*);

// ===== tb/gpio_controller_with_irq_detect_test.sv =====
`timescale 1ns / 1ps

module gpio_controller_with_irq_detect_test;
  import gpioc_pkg::*;

  localparam int unsigned NUM_GPIO_BANKS = 8;
  localparam int unsigned NUM_INTR_BANKS = 2;
  localparam logic [31:0] SRC_MASK_BANK1 = 32'h0000_00ff;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 275;

  typedef struct {
    kind_e       kind;
    logic [7:0]  offset;
    logic [31:0] wdata;
    logic [2:0]  sbank;
    logic [31:0] levels;
  } bus_item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [2:0]  dbank;
    logic [31:0] dlevel;
    logic [31:0] denable;
    logic        irq;
  } gpio_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_READ;
  logic [7:0]  reg_offset_i = '0;
  logic [31:0] write_data_i = '0;
  logic [2:0]  sample_bank_i = '0;
  logic [31:0] sample_levels_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic [2:0]  drive_bank_o;
  logic [31:0] drive_level_o;
  logic [31:0] drive_enable_o;
  logic        irq_out_o;

  // Shadow of the controller state
  logic [31:0] latch_q  [NUM_GPIO_BANKS];
  logic [31:0] dir_q    [NUM_GPIO_BANKS];
  logic [31:0] pins_q   [NUM_GPIO_BANKS];
  logic [31:0] irq_stat [NUM_INTR_BANKS];
  logic [31:0] irq_en   [NUM_INTR_BANKS];
  logic [31:0] irq_lvl  [NUM_INTR_BANKS];
  logic [31:0] irq_inv  [NUM_INTR_BANKS];
  logic [31:0] irq_both [NUM_INTR_BANKS];
  logic [31:0] src_prev [NUM_INTR_BANKS];

  gpio_result_t expected_responses [$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;
  int unsigned  quiet_cycles = 0;

  gpio_controller_with_irq_detect u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .reg_offset_i   (reg_offset_i),
    .write_data_i   (write_data_i),
    .sample_bank_i  (sample_bank_i),
    .sample_levels_i(sample_levels_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .drive_bank_o   (drive_bank_o),
    .drive_level_o  (drive_level_o),
    .drive_enable_o (drive_enable_o),
    .irq_out_o      (irq_out_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one beat to the shadow state and return the response it should give
  function automatic gpio_result_t predict_gpio_response(input bus_item_t it);
    gpio_result_t res;
    logic [5:0]  word;
    logic [2:0]  gb;
    logic        ib;
    logic [31:0] smask;
    logic [31:0] cur;
    logic [31:0] x;
    logic [31:0] px;
    logic [31:0] hit;
    res = '0;
    word = it.offset[7:2];
    gb = word[2:0];
    ib = word[4];
    smask = ib ? SRC_MASK_BANK1 : 32'hffff_ffff;
    if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
      if (!word[5]) begin
        res.dbank = gb;
        if (it.kind == KIND_READ) begin
          case (greg_e'(word[4:3]))
            GREG_DATA: res.rdata = (latch_q[gb] & dir_q[gb]) | (pins_q[gb] & ~dir_q[gb]);
            GREG_DIR:  res.rdata = dir_q[gb];
            default:   res.rdata = '0;
          endcase
        end else begin
          case (greg_e'(word[4:3]))
            GREG_DATA: latch_q[gb] = it.wdata;
            GREG_DIR:  dir_q[gb] = it.wdata;
            GREG_SET:  latch_q[gb] = latch_q[gb] | it.wdata;
            default:   latch_q[gb] = latch_q[gb] & ~it.wdata;
          endcase
        end
      end else if (it.kind == KIND_READ) begin
        case (word[3:0])
          IREG_STATUS: res.rdata = irq_stat[ib];
          IREG_ENABLE: res.rdata = irq_en[ib];
          IREG_TYPE:   res.rdata = irq_lvl[ib];
          IREG_POL:    res.rdata = irq_inv[ib];
          IREG_EDGE:   res.rdata = irq_both[ib];
          default:     res.rdata = '0;
        endcase
      end else begin
        case (word[3:0])
          IREG_STATUS: irq_stat[ib] = irq_stat[ib] & ~it.wdata;
          IREG_ENABLE: irq_en[ib] = it.wdata & smask;
          IREG_TYPE:   irq_lvl[ib] = it.wdata & smask;
          IREG_POL:    irq_inv[ib] = it.wdata & smask;
          IREG_EDGE:   irq_both[ib] = it.wdata & smask;
          default: ;
        endcase
      end
    end else if (it.kind == KIND_PIN) begin
      res.dbank = it.sbank;
      pins_q[it.sbank] = it.levels;
    end else if (it.sbank < NUM_INTR_BANKS) begin
      ib = it.sbank[0];
      smask = ib ? SRC_MASK_BANK1 : 32'hffff_ffff;
      cur = it.levels & smask;
      x = cur ^ irq_inv[ib];
      px = src_prev[ib] ^ irq_inv[ib];
      hit = (irq_both[ib] & (cur ^ src_prev[ib])) | (~irq_both[ib] & x & ~px);
      irq_stat[ib] = irq_stat[ib] | (((irq_lvl[ib] & x) | (~irq_lvl[ib] & hit)) & smask);
      src_prev[ib] = cur;
    end
    res.dlevel = latch_q[res.dbank];
    res.denable = dir_q[res.dbank];
    res.irq = ((irq_stat[0] & irq_en[0]) != '0) || ((irq_stat[1] & irq_en[1]) != '0);
    return res;
  endfunction

  function automatic logic [7:0] gpio_offset(input greg_e grp, input logic [2:0] bank);
    return {1'b0, grp, bank, 2'($urandom_range(0, 3))};
  endfunction

  function automatic logic [7:0] irq_offset(input logic bank1, input logic [3:0] ireg);
    return {1'b1, bank1, ireg, 2'($urandom_range(0, 3))};
  endfunction

  // Hold the beat until it is taken, then record its expected response
  task automatic send_item(input kind_e kind, input logic [7:0] ofs, input logic [31:0] wd,
                           input logic [2:0] sb, input logic [31:0] lv);
    bus_item_t it;
    it = '{kind: kind, offset: ofs, wdata: wd, sbank: sb, levels: lv};
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= it.kind;
    reg_offset_i    <= it.offset;
    write_data_i    <= it.wdata;
    sample_bank_i   <= it.sbank;
    sample_levels_i <= it.levels;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_responses.push_back(predict_gpio_response(it));
    items_sent++;
  endtask

  task automatic read_reg(input logic [7:0] ofs);
    send_item(KIND_READ, ofs, $urandom, 3'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic write_reg(input logic [7:0] ofs, input logic [31:0] data);
    send_item(KIND_WRITE, ofs, data, 3'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic sample_pins(input logic [2:0] bank, input logic [31:0] lv);
    send_item(KIND_PIN, 8'($urandom), $urandom, bank, lv);
  endtask

  task automatic sample_sources(input logic [2:0] bank, input logic [31:0] lv);
    send_item(KIND_SRC, 8'($urandom), $urandom, bank, lv);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    read_reg(gpio_offset(GREG_DATA, 3'd0));
    read_reg(gpio_offset(GREG_DIR, 3'd7));
    read_reg(irq_offset(1'b1, IREG_STATUS));
  endtask

  task automatic test_gpio_bank_regs();
    write_reg(gpio_offset(GREG_DIR, 3'd3), 32'hffff_0000);
    write_reg(gpio_offset(GREG_DATA, 3'd3), 32'ha5a5_a5a5);
    sample_pins(3'd3, 32'h1234_5678);
    read_reg(gpio_offset(GREG_DATA, 3'd3));
    write_reg(gpio_offset(GREG_SET, 3'd3), 32'h0000_000f);
    write_reg(gpio_offset(GREG_CLR, 3'd3), 32'hffff_ffff);
    read_reg({1'b0, GREG_SET, 3'd7, 2'b11});
  endtask

  task automatic test_irq_detection();
    write_reg(irq_offset(1'b0, IREG_ENABLE), 32'hffff_ffff);
    write_reg(irq_offset(1'b0, IREG_TYPE), 32'h0000_000f);
    write_reg(irq_offset(1'b0, IREG_POL), 32'h0000_00f0);
    write_reg(irq_offset(1'b0, IREG_EDGE), 32'h0000_ff00);
    sample_sources(3'd0, 32'hffff_ffff);
    sample_sources(3'd0, 32'h0000_0000);
    read_reg(irq_offset(1'b0, IREG_STATUS));
    write_reg(irq_offset(1'b0, IREG_STATUS), 32'hffff_ffff);
    write_reg(irq_offset(1'b1, IREG_ENABLE), 32'hffff_ffff);
    sample_sources(3'd1, 32'hffff_ffff);
    read_reg(irq_offset(1'b1, IREG_STATUS));
    read_reg(irq_offset(1'b1, IREG_ENABLE));
  endtask

  task automatic test_unmapped_access();
    read_reg(8'hfc);
    write_reg(8'hb0, 32'hffff_ffff);
    sample_sources(3'd5, 32'hffff_ffff);
  endtask

  task automatic run_irq_sequence();
    logic [2:0]  bank;
    logic [31:0] lv;
    bank = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(2, 7)) : 3'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) write_reg(irq_offset(bank[0], IREG_TYPE), $urandom & $urandom);
    if ($urandom_range(0, 9) < 7) write_reg(irq_offset(bank[0], IREG_POL), $urandom);
    if ($urandom_range(0, 9) < 7) write_reg(irq_offset(bank[0], IREG_EDGE), $urandom);
    if ($urandom_range(0, 9) < 7) write_reg(irq_offset(bank[0], IREG_ENABLE), $urandom & $urandom);
    lv = $urandom;
    repeat ($urandom_range(3, 8)) begin
      sample_sources(bank, lv);
      lv = lv ^ ($urandom & $urandom & $urandom);
    end
    read_reg(irq_offset(bank[0], IREG_STATUS));
    write_reg(irq_offset(bank[0], IREG_STATUS), $urandom);
    if ($urandom_range(0, 1) == 0) read_reg(irq_offset(bank[0], 4'($urandom_range(0, 15))));
  endtask

  task automatic run_gpio_sequence();
    logic [2:0] bank;
    bank = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 0) write_reg(gpio_offset(GREG_DIR, bank), $urandom);
    repeat ($urandom_range(1, 4))
      write_reg(gpio_offset(greg_e'($urandom_range(0, 3)), bank), $urandom);
    sample_pins(bank, $urandom);
    read_reg(gpio_offset(GREG_DATA, bank));
    read_reg(gpio_offset(greg_e'($urandom_range(0, 3)), bank));
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned target;
    int unsigned pick;
    target = items_sent + ITEMS_PER_PHASE;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run_irq_sequence();
      end else if (pick < 75) begin
        run_gpio_sequence();
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(kind_e'($urandom_range(0, 3)), 8'($urandom), $urandom,
                    3'($urandom_range(0, 7)), $urandom);
      end
    end
    wait_drained();
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_responses
    gpio_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected response beat, expected none, actual read_data %h",
                 $time, read_data_o);
        mismatches++;
      end else begin
        want = expected_responses.pop_front();
        check_field("read_data", want.rdata, read_data_o);
        check_field("drive_bank", 32'(want.dbank), 32'(drive_bank_o));
        check_field("drive_level", want.dlevel, drive_level_o);
        check_field("drive_enable", want.denable, drive_enable_o);
        check_field("irq_out", 32'(want.irq), 32'(irq_out_o));
      end
    end
  end

  // Stop a hung run: count cycles in which neither channel moves a beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_GPIO_BANKS; i++) begin
      latch_q[i] = '0;
      dir_q[i] = '0;
      pins_q[i] = '0;
    end
    for (int i = 0; i < NUM_INTR_BANKS; i++) begin
      irq_stat[i] = '0;
      irq_en[i] = '0;
      irq_lvl[i] = '0;
      irq_inv[i] = '0;
      irq_both[i] = '0;
      src_prev[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_gpio_bank_regs();
    test_irq_detection();
    test_unmapped_access();
    wait_drained();

    test_random_traffic(0, 0);
    test_random_traffic(46, 0);
    test_random_traffic(0, 46);
    test_random_traffic(20, 20);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
